// File: sv/mpsq_pkg.sv
// mpsq_pkg: shared constants, FSM state type and controller/datapath interface structs.
// No dependencies; imported by every module of the matrix power block.
package mpsq_pkg;

    localparam int MAX_DIM     = 8;
    localparam int ELEM_BITS   = 32;
    localparam int FRAC_BITS   = ELEM_BITS - 2;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int IDX_BITS    = $clog2(MAX_DIM);
    localparam int DIM_BITS    = $clog2(MAX_DIM + 1);
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int POS_BITS    = ADDR_BITS + 1;
    localparam int PROD_BITS   = 2 * ELEM_BITS;
    localparam int SH_BITS     = PROD_BITS - FRAC_BITS;
    localparam int ACC_BITS    = SH_BITS + IDX_BITS;

    // configuration register fields
    localparam int SIZE_BITS   = 4;
    localparam int POW_BITS    = 21;
    localparam int CNT_BITS    = POW_BITS + 1;
    localparam int CFG_BITS    = POW_BITS;

    typedef enum logic {
        CFG_MATRIX_SIZE  = 1'b0,
        CFG_TARGET_POWER = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SQ_ISSUE,
        S_SQ_DRAIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;       // input beat accepted
        logic start;      // load complete, begin squaring
        logic issue;      // issue one multiply-accumulate term
        logic sq_done;    // squaring drained, swap stores
        logic out_mode;   // read port 0 addressed by output indices
        logic out_issue;  // read one result element
    } t_cmd;

    typedef struct packed {
        logic load_fin;
        logic sq_last;
        logic pipe_busy;
        logic more;
        logic out_can_issue;
        logic out_last;
    } t_stat;

endpackage

// File: sv/mpsq_ctrl.sv
// mpsq_ctrl: sequencing FSM for load, repeated squaring and result readout.
// Depends on mpsq_pkg (t_state, t_cmd, t_stat).
module mpsq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  mpsq_pkg::t_stat i_stat,
    output mpsq_pkg::t_cmd  o_cmd,
    output logic          o_stall
);
    import mpsq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_LOAD: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
                if (i_valid && i_stat.load_fin) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SQ_ISSUE;
                end
            end
            S_SQ_ISSUE: begin
                o_cmd.issue = 1'b1;
                if (i_stat.sq_last) begin
                    n_state = S_SQ_DRAIN;
                end
            end
            S_SQ_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    o_cmd.sq_done = 1'b1;
                    n_state       = i_stat.more ? S_SQ_ISSUE : S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.out_mode = 1'b1;
                if (i_stat.out_can_issue) begin
                    o_cmd.out_issue = 1'b1;
                    if (i_stat.out_last) begin
                        n_state = S_LOAD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

endmodule

// File: sv/mpsq_dp.sv
// mpsq_dp: config registers, ping-pong matrix stores, MAC pipeline and output register.
// Depends on mpsq_pkg; driven by mpsq_ctrl through t_cmd, reports through t_stat.
module mpsq_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_idx,
    input  logic [mpsq_pkg::CFG_BITS-1:0]         i_cfg_data,
    input  logic signed [mpsq_pkg::ELEM_BITS-1:0] i_element_value,
    input  mpsq_pkg::t_cmd                        i_cmd,
    output mpsq_pkg::t_stat                       o_stat,
    input  logic                                  i_stall,
    output logic                                  o_valid,
    output logic signed [mpsq_pkg::ELEM_BITS-1:0] o_result_value,
    output logic [mpsq_pkg::IDX_BITS-1:0]         o_result_row,
    output logic [mpsq_pkg::IDX_BITS-1:0]         o_result_col,
    output logic                                  o_last_element
);
    import mpsq_pkg::*;

    function automatic logic [ADDR_BITS-1:0] addr_of(logic [IDX_BITS-1:0] row,
                                                     logic [IDX_BITS-1:0] col);
        return ADDR_BITS'(ADDR_BITS'(row) * ADDR_BITS'(MAX_DIM) + ADDR_BITS'(col));
    endfunction

    // row = pos / dim, counted as independent compares against multiples of dim
    function automatic logic [IDX_BITS-1:0] row_of(logic [POS_BITS-1:0] pos,
                                                   logic [DIM_BITS-1:0] dim);
        logic [IDX_BITS-1:0] cnt;
        cnt = '0;
        for (int k = 1; k < MAX_DIM; k++) begin
            if (POS_BITS'(k) * POS_BITS'(dim) <= pos) begin
                cnt = cnt + 1'b1;
            end
        end
        return cnt;
    endfunction

    function automatic logic [ELEM_BITS-1:0] sat(logic signed [ACC_BITS-1:0] v);
        logic signed [ACC_BITS-1:0] hi;
        logic signed [ACC_BITS-1:0] lo;
        hi = {{(ACC_BITS - ELEM_BITS + 1){1'b0}}, {(ELEM_BITS - 1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            return ELEM_BITS'(hi);
        end else if (v < lo) begin
            return ELEM_BITS'(lo);
        end
        return ELEM_BITS'(v);
    endfunction

    // configuration
    logic [SIZE_BITS-1:0] r_size;
    logic [POW_BITS-1:0]  r_pow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_BITS'(MAX_DIM);
            r_pow  <= POW_BITS'(2);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MATRIX_SIZE:  r_size <= i_cfg_data[SIZE_BITS-1:0];
                CFG_TARGET_POWER: r_pow  <= i_cfg_data[POW_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic [DIM_BITS-1:0] w_dim;
    logic [IDX_BITS-1:0] w_lim;
    logic [POS_BITS-1:0] w_total;
    logic [CNT_BITS-1:0] w_max_pow;

    always_comb begin
        if (r_size < SIZE_BITS'(2)) begin
            w_dim = DIM_BITS'(2);
        end else if (r_size > SIZE_BITS'(MAX_DIM)) begin
            w_dim = DIM_BITS'(MAX_DIM);
        end else begin
            w_dim = DIM_BITS'(r_size);
        end
    end

    assign w_lim     = IDX_BITS'(w_dim - 1'b1);
    assign w_total   = POS_BITS'(w_dim) * POS_BITS'(w_dim);
    assign w_max_pow = CNT_BITS'((CNT_BITS'(r_pow) + 1'b1) >> 1);

    // load position
    logic [POS_BITS-1:0]  r_pos;
    logic [POS_BITS-1:0]  w_pos_p1;
    logic [IDX_BITS-1:0]  w_ld_row;
    logic [IDX_BITS-1:0]  w_ld_col;
    logic                 w_ld_we;

    assign w_pos_p1 = r_pos + 1'b1;
    assign w_ld_row = row_of(r_pos, w_dim);
    assign w_ld_col = IDX_BITS'(r_pos - POS_BITS'(w_ld_row) * POS_BITS'(w_dim));
    assign w_ld_we  = i_cmd.load && (r_pos < w_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_cmd.load) begin
            r_pos <= (w_pos_p1 >= w_total) ? '0 : w_pos_p1;
        end
    end

    // squaring count and store select
    logic [CNT_BITS-1:0] r_cnt;
    logic [CNT_BITS-1:0] w_cnt_x2;
    logic                r_cur_a;

    assign w_cnt_x2 = {r_cnt[CNT_BITS-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= CNT_BITS'(2);
            r_cur_a <= 1'b1;
        end else if (i_cmd.start) begin
            r_cnt   <= CNT_BITS'(1);
            r_cur_a <= 1'b1;
        end else if (i_cmd.sq_done) begin
            r_cnt   <= w_cnt_x2;
            r_cur_a <= ~r_cur_a;
        end
    end

    // row / col / term indices; row and col are shared by squaring and readout
    logic [IDX_BITS-1:0] r_row;
    logic [IDX_BITS-1:0] r_col;
    logic [IDX_BITS-1:0] r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_k   <= '0;
        end else if (i_cmd.start || i_cmd.sq_done) begin
            r_row <= '0;
            r_col <= '0;
            r_k   <= '0;
        end else if (i_cmd.issue) begin
            if (r_k == w_lim) begin
                r_k <= '0;
                if (r_col == w_lim) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end else begin
                r_k <= r_k + 1'b1;
            end
        end else if (i_cmd.out_issue) begin
            if (r_col == w_lim) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // MAC pipeline: issue -> read/p1 -> multiply/p2 -> accumulate and write
    logic                 r_p1_v;
    logic                 r_p1_first;
    logic                 r_p1_last;
    logic [ADDR_BITS-1:0] r_p1_wa;
    logic                 r_p2_v;
    logic                 r_p2_first;
    logic                 r_p2_last;
    logic [ADDR_BITS-1:0] r_p2_wa;
    logic signed [PROD_BITS-1:0] r_prod;
    logic signed [ACC_BITS-1:0]  r_acc;
    logic signed [SH_BITS-1:0]   w_sh;
    logic signed [ACC_BITS-1:0]  w_acc;
    logic [ELEM_BITS-1:0]        w_sat;

    // stores
    logic [ELEM_BITS-1:0] r_mem_a [STORE_DEPTH];
    logic [ELEM_BITS-1:0] r_mem_b [STORE_DEPTH];
    logic [ELEM_BITS-1:0] r_a_rd0;
    logic [ELEM_BITS-1:0] r_a_rd1;
    logic [ELEM_BITS-1:0] r_b_rd0;
    logic [ELEM_BITS-1:0] r_b_rd1;
    logic [ADDR_BITS-1:0] w_ra0;
    logic [ADDR_BITS-1:0] w_ra1;
    logic                 w_sq_we;
    logic                 w_we_a;
    logic                 w_we_b;
    logic [ADDR_BITS-1:0] w_wa_a;
    logic [ELEM_BITS-1:0] w_wd_a;
    logic signed [ELEM_BITS-1:0] w_sa;
    logic signed [ELEM_BITS-1:0] w_sb;

    assign w_ra0   = i_cmd.out_mode ? addr_of(r_row, r_col) : addr_of(r_row, r_k);
    assign w_ra1   = addr_of(r_k, r_col);
    assign w_sq_we = r_p2_v && r_p2_last;
    assign w_we_a  = w_ld_we || (w_sq_we && !r_cur_a);
    assign w_we_b  = w_sq_we && r_cur_a;
    assign w_wa_a  = w_ld_we ? addr_of(w_ld_row, w_ld_col) : r_p2_wa;
    assign w_wd_a  = w_ld_we ? i_element_value : w_sat;

    always_ff @(posedge i_clk) begin
        if (w_we_a) begin
            r_mem_a[w_wa_a] <= w_wd_a;
        end
        r_a_rd0 <= r_mem_a[w_ra0];
        r_a_rd1 <= r_mem_a[w_ra1];
    end

    always_ff @(posedge i_clk) begin
        if (w_we_b) begin
            r_mem_b[r_p2_wa] <= w_sat;
        end
        r_b_rd0 <= r_mem_b[w_ra0];
        r_b_rd1 <= r_mem_b[w_ra1];
    end

    assign w_sa  = r_cur_a ? r_a_rd0 : r_b_rd0;
    assign w_sb  = r_cur_a ? r_a_rd1 : r_b_rd1;
    // arithmetic shift floors, same as truncating the low fraction bits
    assign w_sh  = SH_BITS'(r_prod >>> FRAC_BITS);
    assign w_acc = (r_p2_first ? '0 : r_acc) + ACC_BITS'(w_sh);
    assign w_sat = sat(w_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
        end else begin
            r_p1_v <= i_cmd.issue;
            r_p2_v <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_first <= (r_k == '0);
        r_p1_last  <= (r_k == w_lim);
        r_p1_wa    <= addr_of(r_row, r_col);
        r_p2_first <= r_p1_first;
        r_p2_last  <= r_p1_last;
        r_p2_wa    <= r_p1_wa;
        r_prod     <= PROD_BITS'(w_sa) * PROD_BITS'(w_sb);
        if (r_p2_v) begin
            r_acc <= w_acc;
        end
    end

    // readout: one read slot, then the output register
    logic                r_q_v;
    logic [IDX_BITS-1:0] r_q_row;
    logic [IDX_BITS-1:0] r_q_col;
    logic                r_q_last;
    logic                w_out_last;

    assign w_out_last = (r_row == w_lim) && (r_col == w_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_v   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_q_v <= i_cmd.out_issue;
            if (r_q_v) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_issue) begin
            r_q_row  <= r_row;
            r_q_col  <= r_col;
            r_q_last <= w_out_last;
        end
        if (r_q_v) begin
            o_result_value <= r_cur_a ? r_a_rd0 : r_b_rd0;
            o_result_row   <= r_q_row;
            o_result_col   <= r_q_col;
            o_last_element <= r_q_last;
        end
    end

    always_comb begin
        o_stat               = '0;
        o_stat.load_fin      = (w_pos_p1 >= w_total);
        o_stat.sq_last       = (r_row == w_lim) && (r_col == w_lim) && (r_k == w_lim);
        o_stat.pipe_busy     = r_p1_v || r_p2_v;
        o_stat.more          = (w_cnt_x2 <= w_max_pow);
        o_stat.out_can_issue = !r_q_v && (!o_valid || !i_stall);
        o_stat.out_last      = w_out_last;
    end

endmodule

// File: sv/matrix_power_by_squaring.sv
// Matrix power by repeated squaring, Q2.30, sizes 2..8. Top level over mpsq_ctrl + mpsq_dp.
// Load: one element beat per cycle while in the load phase. After the last element, each
// squaring runs on the single MAC pipeline (two reads of the source store per cycle, one
// term each); s = 1 + floor(log2(ceil(power/2))) squarings (s = 1 for power below 3).
// Readout: a result beat is read only with the read slot empty and the output register free.
// Reset (i_rst_n low, synchronous) resets control and config (size 8, power 2), not stores.
module matrix_power_by_squaring (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_idx,
    input  logic [mpsq_pkg::CFG_BITS-1:0]         i_cfg_data,
    // element input channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [mpsq_pkg::ELEM_BITS-1:0] i_element_value,
    // result output channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [mpsq_pkg::ELEM_BITS-1:0] o_result_value,
    output logic [mpsq_pkg::IDX_BITS-1:0]         o_result_row,
    output logic [mpsq_pkg::IDX_BITS-1:0]         o_result_col,
    output logic                                  o_last_element
);
    import mpsq_pkg::*;

    // The controller only steps through phases; every counter, the stores and the
    // output register live in the datapath. Input beats are taken only in the load
    // phase. A pending last result beat does not hold off the next load.
    t_cmd  w_cmd;
    t_stat w_stat;

    mpsq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_stall (o_stall)
    );

    // Squaring ping-pongs store A -> B -> A; the load always fills store A.
    // Each result element is a row sum of floored products, saturated on write-back.
    mpsq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_element_value (i_element_value),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_result_value  (o_result_value),
        .o_result_row    (o_result_row),
        .o_result_col    (o_result_col),
        .o_last_element  (o_last_element)
    );

endmodule

// File: sv/mpsq_chk.sv
// mpsq_chk: port-level assertions for matrix_power_by_squaring, bound to the top level.
// Depends on mpsq_pkg for field widths.
module mpsq_chk (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  o_stall,
    input logic                                  o_valid,
    input logic                                  i_stall,
    input logic signed [mpsq_pkg::ELEM_BITS-1:0] o_result_value,
    input logic [mpsq_pkg::IDX_BITS-1:0]         o_result_row,
    input logic [mpsq_pkg::IDX_BITS-1:0]         o_result_col,
    input logic                                  o_last_element
);
    import mpsq_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result_value)
            && $stable(o_result_row) && $stable(o_result_col) && $stable(o_last_element)))
        else $error("stalled result beat changed");

    // last beat sits on the diagonal corner, never at row zero
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_element) |-> (o_result_row == o_result_col && o_result_row != '0))
        else $error("last beat not at bottom-right element");

    // no element is taken while a result matrix is still being read out
    a_no_load_mid_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_element) |-> o_stall)
        else $error("input accepted during readout");

    // one read slot per beat: a taken result beat leaves a gap before the next
    a_beat_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) |=> !o_valid)
        else $error("result beats issued back to back");

endmodule

bind matrix_power_by_squaring mpsq_chk u_mpsq_chk (.*);

// File: verif/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for matrix_power_by_squaring: loads matrices, predicts
// the powered result per element and checks every result beat; also uses mpsq_pkg.
module tb;
    import mpsq_pkg::*;

    // one expected result beat
    typedef struct packed {
        logic signed [ELEM_BITS-1:0] value;
        logic [IDX_BITS-1:0]         row;
        logic [IDX_BITS-1:0]         col;
        logic                        last;
    } t_powered_elem;

    localparam longint SAT_HI = (longint'(1) << (ELEM_BITS - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;
    localparam int GAP_PCT = 18;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_we;
    logic                        cfg_idx;
    logic [CFG_BITS-1:0]         cfg_data;
    logic                        elem_vld = 1'b0;
    logic                        elem_stall;
    logic signed [ELEM_BITS-1:0] elem_data = '0;
    logic                        res_vld;
    logic                        res_stall = 1'b0;
    logic signed [ELEM_BITS-1:0] res_value;
    logic [IDX_BITS-1:0]         res_row;
    logic [IDX_BITS-1:0]         res_col;
    logic                        res_last;

    // stimulus and scoreboard storage
    logic signed [ELEM_BITS-1:0] element_feed[$];
    t_powered_elem               pending_results[$];

    // predictor state: own copy of the config and the current matrix
    logic [SIZE_BITS-1:0]        size_reg;
    logic [POW_BITS-1:0]         power_reg;
    logic [POS_BITS-1:0]         load_pos;
    longint                      pwr_mat[STORE_DEPTH];

    logic                        steady;      // no gaps on either side while set
    int                          fail_count;
    int                          beats_in;
    int                          beats_out;
    int                          settings_done;

    matrix_power_by_squaring uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_valid         (elem_vld),
        .o_stall         (elem_stall),
        .i_element_value (elem_data),
        .o_valid         (res_vld),
        .i_stall         (res_stall),
        .o_result_value  (res_value),
        .o_result_row    (res_row),
        .o_result_col    (res_col),
        .o_last_element  (res_last)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // size register is clamped into 2..MAX_DIM
    function automatic int dim_of(logic [SIZE_BITS-1:0] s);
        if (s < 2) return 2;
        if (s > MAX_DIM) return MAX_DIM;
        return int'(s);
    endfunction

    function automatic bit take_gap();
        return !steady && ($urandom_range(99) < GAP_PCT);
    endfunction

    // append one element to the stimulus queue
    function automatic void feed_elem(logic signed [ELEM_BITS-1:0] v);
        element_feed = {element_feed, v};
    endfunction

    // one squaring of the n x n corner of pwr_mat, Q2.30:
    // products floor-shifted by FRAC_BITS, row sum exact, then saturated
    function automatic void square_power_matrix(int n);
        longint sq[STORE_DEPTH];
        longint acc;
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                acc = 0;
                for (int k = 0; k < n; k++)
                    acc += (pwr_mat[r * MAX_DIM + k] * pwr_mat[k * MAX_DIM + c]) >>> FRAC_BITS;
                if (acc > SAT_HI) acc = SAT_HI;
                else if (acc < SAT_LO) acc = SAT_LO;
                sq[r * MAX_DIM + c] = acc;
            end
        end
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                pwr_mat[r * MAX_DIM + c] = sq[r * MAX_DIM + c];
    endfunction

    // accepted element beat: store it; on the last element of the matrix
    // square once, then keep squaring while the doubling count <= ceil(power/2)
    function automatic void predict_element(logic signed [ELEM_BITS-1:0] v);
        int            n;
        int            total;
        longint        half;
        t_powered_elem e;
        n     = dim_of(size_reg);
        total = n * n;
        if (load_pos < total)
            pwr_mat[(load_pos / n) * MAX_DIM + (load_pos % n)] = longint'(v);
        load_pos = load_pos + 1'b1;
        if (load_pos < total) return;

        square_power_matrix(n);
        half = (longint'(power_reg) + 1) / 2;
        for (longint cnt = 2; cnt <= half; cnt = cnt * 2)
            square_power_matrix(n);

        for (int i = 0; i < total; i++) begin
            e.value = ELEM_BITS'(pwr_mat[(i / n) * MAX_DIM + (i % n)]);
            e.row   = IDX_BITS'(i / n);
            e.col   = IDX_BITS'(i % n);
            e.last  = (i + 1 == total);
            pending_results = {pending_results, e};
        end
        load_pos = '0;
    endfunction

    // ---------------------------------------------------------------
    // Element driver: one beat per handshake, random gaps, payload
    // held while stalled
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            elem_vld <= 1'b0;
        end else if (!elem_vld || !elem_stall) begin
            if (element_feed.size() != 0 && !take_gap()) begin
                elem_vld  <= 1'b1;
                elem_data <= element_feed.pop_front();
            end else begin
                elem_vld <= 1'b0;
            end
        end
    end

    // every accepted element beat goes through the predictor
    always @(posedge clk) begin
        if (rst_n && elem_vld && !elem_stall) begin
            predict_element(elem_data);
            beats_in++;
        end
    end

    // ---------------------------------------------------------------
    // Result monitor: random back-pressure, in-order compare
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        t_powered_elem want;
        res_stall <= take_gap();
        if (rst_n && res_vld && !res_stall) begin
            beats_out++;
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: row %0d col %0d value %0d",
                       res_row, res_col, res_value);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_value !== want.value) begin
                    $error("result_value mismatch: expected %0d, got %0d",
                           want.value, res_value);
                    fail_count++;
                end
                if (res_row !== want.row) begin
                    $error("result_row mismatch: expected %0d, got %0d", want.row, res_row);
                    fail_count++;
                end
                if (res_col !== want.col) begin
                    $error("result_col mismatch: expected %0d, got %0d", want.col, res_col);
                    fail_count++;
                end
                if (res_last !== want.last) begin
                    $error("last_element mismatch: expected %0d, got %0d",
                           want.last, res_last);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequencing helpers
    // ---------------------------------------------------------------

    // sender pauses until the feed is drained and every result is back
    task automatic settle();
        do @(negedge clk);
        while (element_feed.size() != 0 || elem_vld || pending_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // both registers written back to back; only called with the block idle
    task automatic write_cfg(logic [SIZE_BITS-1:0] size, logic [POW_BITS-1:0] power);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MATRIX_SIZE;
        cfg_data <= CFG_BITS'(size);
        @(posedge clk);
        cfg_idx  <= CFG_TARGET_POWER;
        cfg_data <= CFG_BITS'(power);
        @(posedge clk);
        cfg_we   <= 1'b0;
        size_reg  = size;
        power_reg = power;
        settings_done++;
        @(negedge clk);
    endtask

    // random n x n matrix: full-range bits, small values that stay in range
    // for a while, or a near-identity matrix that survives large powers
    task automatic queue_matrix(int n);
        int                          style;
        int                          lim;
        logic signed [ELEM_BITS-1:0] v;
        style = $urandom_range(0, 3);
        lim   = (1 << FRAC_BITS) / n;
        for (int i = 0; i < n * n; i++) begin
            case (style)
                0: v = $urandom();
                3: v = (i / n == i % n) ? 32'sh4000_0000 - $urandom_range(0, 4095)
                                        : $urandom_range(0, 511) - 256;
                default: v = $urandom_range(0, 2 * lim) - lim;
            endcase
            feed_elem(v);
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int                   random_items;
        int                   phase_no;
        int                   n;
        int                   mats;
        int                   pick;
        logic [SIZE_BITS-1:0] size_sel;
        logic [POW_BITS-1:0]  power_sel;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_MATRIX_SIZE;
        cfg_data  = '0;
        steady    = 1'b0;
        fail_count    = 0;
        beats_in      = 0;
        beats_out     = 0;
        settings_done = 0;
        // predictor mirrors the reset state
        size_reg  = MAX_DIM;
        power_reg = 2;
        load_pos  = '0;
        foreach (pwr_mat[i]) pwr_mat[i] = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed ---
        // size below range (used as 2), power zero: extremes of the element field
        write_cfg(4'd0, 21'd0);
        feed_elem(32'sh7FFF_FFFF);
        feed_elem(32'sh8000_0000);
        feed_elem(32'sh0000_0000);
        feed_elem(-32'sd1);
        settle();

        // size one, power one: all minus two, sums saturate high
        write_cfg(4'd1, 21'd1);
        repeat (4) feed_elem(32'sh8000_0000);
        settle();

        // two squarings; tiny negative terms check floor truncation
        write_cfg(4'd2, 21'd4);
        feed_elem(-32'sd1);
        feed_elem(32'sd1);
        feed_elem(32'sh7FFF_FFFF);
        feed_elem(32'sd3);
        settle();

        // 3x3 at the largest power field value: longest squaring chain
        write_cfg(4'd3, 21'h1F_FFFF);
        for (int i = 0; i < 9; i++)
            feed_elem((i % 4 == 0) ? 32'sh3FFF_F000 : $urandom_range(0, 1023) - 512);
        settle();

        // --- random phases: new config each phase, mostly small sizes ---
        random_items = 0;
        phase_no     = 0;
        while (random_items < 200) begin
            pick = $urandom_range(99);
            if (pick < 55)      size_sel = $urandom_range(2, 3);
            else if (pick < 80) size_sel = $urandom_range(4, 5);
            else if (pick < 90) size_sel = $urandom_range(6, 8);
            else if (pick < 95) size_sel = $urandom_range(0, 1);
            else                size_sel = $urandom_range(9, 15);

            pick = $urandom_range(99);
            if (pick < 60)      power_sel = $urandom_range(0, 40);
            else if (pick < 80) power_sel = $urandom_range(41, 5000);
            else if (pick < 90) power_sel = $urandom_range(0, 21'h1F_FFFF);
            else begin
                case ($urandom_range(0, 4))
                    0: power_sel = 0;
                    1: power_sel = 1;
                    2: power_sel = 3;
                    3: power_sel = 21'h10_0000;
                    default: power_sel = 21'h1F_FFFF;
                endcase
            end

            // a stretch of phases with no gaps on either side
            steady = (phase_no >= 3 && phase_no < 7);

            settle();
            write_cfg(size_sel, power_sel);
            n    = dim_of(size_sel);
            mats = (n >= 6) ? 1 : $urandom_range(1, 3);
            repeat (mats) queue_matrix(n);
            random_items += mats * n * n;
            phase_no++;
        end

        steady = 1'b0;
        settle();
        repeat (20) @(negedge clk);

        $display("Run covered %0d element beats and %0d result beats over %0d settings",
                 beats_in, beats_out, settings_done);
        $display("(sizes clamped low and high, powers from zero to the field maximum).");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // hang guard, several times the slowest expected run
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: matrix_power_by_squaring.f
sv/mpsq_pkg.sv
sv/mpsq_ctrl.sv
sv/mpsq_dp.sv
sv/matrix_power_by_squaring.sv
sv/mpsq_chk.sv
verif/tb.sv
